/* src/vtcm_pkg.sv */
// Package for the vertex/triangle contact merge block.
// Holds field widths, outcome codes, register indexes and the cell request type.
// No dependencies.
`default_nettype none
package vtcm_pkg;
  localparam int CoordW = 20;
  localparam int NormW = 16;
  localparam int PosW = 60;
  localparam int NrmW = 48;
  localparam int DepthW = 20;
  localparam int DefaultSlots = 16;

  localparam logic [2:0] OUT_BAND = 3'd0;
  localparam logic [2:0] OUT_OUTSIDE = 3'd1;
  localparam logic [2:0] OUT_MERGED = 3'd2;
  localparam logic [2:0] OUT_APPENDED = 3'd3;
  localparam logic [2:0] OUT_FULL = 3'd4;
  localparam logic [2:0] OUT_CLEARED = 3'd5;

  localparam logic [1:0] REG_MIN_DEPTH = 2'd0;
  localparam logic [1:0] REG_MAX_DEPTH = 2'd1;
  localparam logic [1:0] REG_MERGE_DIST = 2'd2;
  localparam logic [1:0] REG_MERGE_COS = 2'd3;

  // Request that travels down the cell chain, one hop per cycle.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [PosW-1:0]  pos;
    logic [NrmW-1:0]  nrm;
    logic signed [DepthW-1:0] depth;
  } probe_t;
endpackage
`default_nettype wire

/* src/vtcm_cell.sv */
// One contact slot: stores a contact and compares a passing request against it.
// Depends on vtcm_pkg.
`default_nettype none
module vtcm_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           clear,
  input  wire logic [15:0]    merge_dist_sq,
  input  wire logic [14:0]    merge_cos,
  input  wire vtcm_pkg::probe_t probe_in,
  input  wire logic           append,
  output vtcm_pkg::probe_t    probe_out,
  output logic                hit,
  output logic                occupied
);
  import vtcm_pkg::*;

  logic [PosW-1:0] pos;
  logic [NrmW-1:0] nrm;
  logic signed [DepthW-1:0] depth;
  logic occ;

  // Stage one registers: per-axis squares and products.
  logic signed [41:0] sq [3];
  logic signed [31:0] pr [3];
  logic stage_valid;
  probe_t stage;
  logic signed [43:0] dsq;
  logic signed [33:0] dn;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [20:0] d;
      d = 21'(signed'(probe_in.pos[k*CoordW +: CoordW]))
        - 21'(signed'(pos[k*CoordW +: CoordW]));
      sq[k] <= 42'(d * d);
      pr[k] <= 32'(signed'(probe_in.nrm[k*NormW +: NormW]))
             * 32'(signed'(nrm[k*NormW +: NormW]));
    end
    stage <= probe_in;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= probe_in.valid;
    end
  end

  assign dsq = 44'(sq[0]) + 44'(sq[1]) + 44'(sq[2]);
  assign dn = 34'(pr[0]) + 34'(pr[1]) + 34'(pr[2]);

  // Match only on a live request not yet claimed by an earlier cell.
  // The normal dot is signed, so the threshold is compared as signed too.
  assign hit = stage_valid && occ && !stage.found
            && (dsq < 44'($unsigned(merge_dist_sq)))
            && (dn > $signed(34'({merge_cos, 14'd0})));

  always_comb begin
    probe_out = stage;
    probe_out.valid = stage_valid;
    if (hit) probe_out.found = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      occ <= 1'b0;
    end else if (append) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      pos <= probe_in.pos;
      nrm <= probe_in.nrm;
      depth <= probe_in.depth;
    end else if (hit && stage.depth < depth) begin
      depth <= stage.depth;
    end
  end

  assign occupied = occ;
endmodule
`default_nettype wire

/* src/vtcm_geom.sv */
// Geometry front end: depth, band test, inside test and flipped normal.
// Multi-cycle sequencer that reuses its multipliers across steps; depends on vtcm_pkg.
`default_nettype none
module vtcm_geom (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [59:0] vertex,
  input  wire logic [59:0] tri_a,
  input  wire logic [59:0] tri_b,
  input  wire logic [59:0] tri_c,
  input  wire logic [47:0] tri_normal,
  input  wire logic        flip_normal,
  input  wire logic signed [19:0] min_depth,
  input  wire logic signed [19:0] max_depth,
  output logic             done,
  output logic [2:0]       verdict,
  output logic signed [19:0] depth,
  output logic [47:0]      stored_nrm
);
  import vtcm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_DEPTH = 5'b00010, S_CROSS = 5'b00100,
    S_DOT = 5'b01000, S_DONE = 5'b10000
  } gstate_t;

  gstate_t state;
  logic [1:0] step;
  logic signed [19:0] v [3], p [3][3], n [3];
  logic signed [37:0] acc;
  logic signed [42:0] cr [3];
  logic signed [62:0] ed [3];
  logic signed [21:0] e [3], dd [3];
  logic signed [42:0] cx;
  logic signed [62:0] dotv;
  logic signed [37:0] sum_r;
  logic signed [24:0] dep_w;

  // Edge vectors for the edge selected by step.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e[k] = 22'(p[(step == 2'd2) ? 0 : step + 2'd1][k]) - 22'(p[step][k]);
      dd[k] = 22'(v[k]) - 22'(p[step][k]);
    end
    cx = 43'(e[1] * dd[2]);
    dotv = 63'(cr[0] * 43'(n[0])) + 63'(cr[1] * 43'(n[1]))
         + 63'(cr[2] * 43'(n[2]));
    sum_r = acc + 38'sd8192;
    dep_w = 25'(sum_r >>> 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            for (int k = 0; k < 3; k++) begin
              v[k] <= vertex[k*20 +: 20];
              p[0][k] <= tri_a[k*20 +: 20];
              p[1][k] <= tri_b[k*20 +: 20];
              p[2][k] <= tri_c[k*20 +: 20];
              n[k] <= 20'(signed'(tri_normal[k*16 +: 16]));
              stored_nrm[k*16 +: 16] <= !flip_normal ? tri_normal[k*16 +: 16]
                : (tri_normal[k*16 +: 16] == 16'h8000) ? 16'h7fff
                : 16'(-signed'(tri_normal[k*16 +: 16]));
            end
            acc <= '0;
            step <= '0;
            state <= S_DEPTH;
          end
        end
        S_DEPTH: begin
          acc <= acc + 38'((22'(p[0][step]) - 22'(v[step])) * 38'(n[step]));
          if (step == 2'd2) begin
            step <= '0;
            state <= S_CROSS;
          end else begin
            step <= step + 2'd1;
          end
        end
        S_CROSS: begin
          depth <= (dep_w > 25'sd524287) ? 20'sd524287
                 : (dep_w < -25'sd524288) ? -20'sd524288 : 20'(dep_w);
          cr[0] <= cx - 43'(e[2] * dd[1]);
          cr[1] <= 43'(e[2] * dd[0]) - 43'(e[0] * dd[2]);
          cr[2] <= 43'(e[0] * dd[1]) - 43'(e[1] * dd[0]);
          state <= S_DOT;
        end
        S_DOT: begin
          ed[step] <= dotv;
          if (step == 2'd2) begin
            state <= S_DONE;
          end else begin
            step <= step + 2'd1;
            state <= S_CROSS;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          if (!(depth > min_depth && depth < max_depth)) verdict <= OUT_BAND;
          else if (!((!ed[0][62] && !ed[1][62] && !ed[2][62]) ||
                     ((ed[0] <= 0) && (ed[1] <= 0) && (ed[2] <= 0))))
            verdict <= OUT_OUTSIDE;
          else verdict <= OUT_APPENDED;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/vertex_triangle_contact_merge.sv */
// Top level of the vertex/triangle contact merge block.
// Depends on vtcm_pkg, vtcm_geom and vtcm_cell.
//
// Usage: raise start with op and the geometry fields while busy is low; the
// request is taken at that edge. A clear (op 0) passes through T_OUT before
// done rises. A test runs the geometry sequencer (depth, then cross and dot
// products for each edge), then, on a hit, sends a request down the chain of
// CONTACT_SLOTS cells, one cell per cycle; each cell compares it against its
// stored contact and the first occupied match claims it and keeps the
// smaller depth. The result appears on outcome, contact_index, contact_total
// and depth for one cycle with done high. The receiver cannot stall; busy
// falls in the cycle the result is shown, so the next request may be taken
// at that edge. Configuration writes use cfg_valid/cfg_ready with cfg_index
// and cfg_data and are always ready. Reset empties the list and restores the
// register defaults.
`default_nettype none
module vertex_triangle_contact_merge #(
  parameter int CONTACT_SLOTS = vtcm_pkg::DefaultSlots
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [59:0] vertex,
  input  wire logic [59:0] tri_a,
  input  wire logic [59:0] tri_b,
  input  wire logic [59:0] tri_c,
  input  wire logic [47:0] tri_normal,
  input  wire logic        flip_normal,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output logic             done,
  output logic [2:0]       outcome,
  output logic [3:0]       contact_index,
  output logic [4:0]       contact_total,
  output logic signed [19:0] depth
);
  import vtcm_pkg::*;

  localparam int IdxW = (CONTACT_SLOTS > 1) ? $clog2(CONTACT_SLOTS) : 1;
  localparam int CntW = $clog2(CONTACT_SLOTS + 1);
  localparam int WalkW = $clog2(CONTACT_SLOTS + 3);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001, T_GEOM = 4'b0010, T_WALK = 4'b0100, T_OUT = 4'b1000
  } tstate_t;

  tstate_t state;
  logic signed [19:0] min_depth, max_depth;
  logic [15:0] merge_dist_sq;
  logic [14:0] merge_cos;
  logic [CntW-1:0] count;
  logic [WalkW-1:0] walk;
  logic clear;
  logic g_start, g_done;
  logic [2:0] g_verdict;
  logic signed [19:0] g_depth;
  logic [47:0] g_nrm;
  logic [59:0] vtx;
  probe_t chain [CONTACT_SLOTS+1];
  logic [CONTACT_SLOTS-1:0] hits, occs, app;
  logic [IdxW-1:0] hit_idx;
  logic hit_any;
  logic [IdxW-1:0] m_idx;
  logic m_found;
  probe_t tail;

  assign cfg_ready = 1'b1;
  assign busy = (state != T_IDLE);
  assign g_start = start && !busy && op;
  assign clear = start && !busy && !op;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth <= '0;
      max_depth <= 20'sd1600;
      merge_dist_sq <= 16'd26;
      merge_cos <= 15'd14746;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_DEPTH: min_depth <= cfg_data;
        REG_MAX_DEPTH: max_depth <= cfg_data;
        REG_MERGE_DIST: merge_dist_sq <= cfg_data[15:0];
        REG_MERGE_COS: merge_cos <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  vtcm_geom u_geom (
    .clk, .rst, .start(g_start), .vertex, .tri_a, .tri_b, .tri_c,
    .tri_normal, .flip_normal, .min_depth, .max_depth,
    .done(g_done), .verdict(g_verdict), .depth(g_depth), .stored_nrm(g_nrm)
  );

  always_ff @(posedge clk) begin
    if (g_start) vtx <= vertex;
  end

  // Chain entry: one request launched when geometry reports a hit.
  always_comb begin
    chain[0].valid = g_done && (g_verdict == OUT_APPENDED);
    chain[0].found = 1'b0;
    chain[0].pos = vtx;
    chain[0].nrm = g_nrm;
    chain[0].depth = g_depth;
  end

  // The first free cell takes the request once the walk found no match.
  for (genvar i = 0; i < CONTACT_SLOTS; i++) begin : g_cells
    assign app[i] = (state == T_WALK) && (walk == WalkW'(CONTACT_SLOTS + 1))
                 && !m_found
                 && (count == CntW'(i));
    vtcm_cell u_cell (
      .clk, .rst, .clear, .merge_dist_sq, .merge_cos,
      .probe_in((i == 0) ? chain[0] : chain[i]), .append(app[i]),
      .probe_out(chain[i+1]), .hit(hits[i]), .occupied(occs[i])
    );
  end

  // Index of the cell that claimed the request in this cycle.
  always_comb begin
    hit_idx = '0;
    hit_any = |hits;
    for (int i = 0; i < CONTACT_SLOTS; i++) if (hits[i]) hit_idx = IdxW'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (clear) begin
            count <= '0;
            outcome <= OUT_CLEARED;
            contact_index <= '0;
            contact_total <= '0;
            depth <= '0;
            state <= T_OUT;
          end else if (g_start) begin
            state <= T_GEOM;
          end
        end
        T_GEOM: begin
          if (g_done) begin
            depth <= g_depth;
            contact_index <= '0;
            walk <= '0;
            m_found <= 1'b0;
            if (g_verdict != OUT_APPENDED) begin
              outcome <= g_verdict;
              contact_total <= 5'(count);
              state <= T_OUT;
            end else begin
              state <= T_WALK;
            end
          end
        end
        T_WALK: begin
          walk <= walk + 1'b1;
          if (hit_any) begin
            m_found <= 1'b1;
            m_idx <= hit_idx;
          end
          if (walk == WalkW'(CONTACT_SLOTS + 1)) begin
            contact_total <= 5'(count);
            if (m_found) begin
              outcome <= OUT_MERGED;
              contact_index <= 4'(m_idx);
            end else if (count < CntW'(CONTACT_SLOTS)) begin
              outcome <= OUT_APPENDED;
              contact_index <= 4'(count);
              count <= count + 1'b1;
              contact_total <= 5'(count + 1'b1);
            end else begin
              outcome <= OUT_FULL;
            end
            state <= T_OUT;
          end
        end
        T_OUT: begin
          done <= 1'b1;
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // The request reaches the tail in the cycle after the last cell compares.
  always_ff @(posedge clk) begin
    tail <= chain[CONTACT_SLOTS];
  end

  logic unused_ok;
  assign unused_ok = ^{tail, occs};
endmodule
`default_nettype wire
